// ===== design/iorob_pkg.sv =====
// Shared constants and controller/datapath interface types for the in-order reorder buffer.
`timescale 1ns / 1ps

package iorob_pkg;

    localparam int SEQ_W             = 32;
    localparam int WORD_W            = 32;
    localparam int TDATA_W           = SEQ_W + 2 * WORD_W;
    localparam int DEF_WINDOW        = 16;
    localparam int DEF_PAYLOAD_WIDTH = 32;

    // Commands from the controller to the datapath. At most one is set per cycle.
    typedef struct packed {
        logic emit_in;    // accept the input item and emit it in order
        logic reject_in;  // accept the input item and return it flagged
        logic store_in;   // accept the input item and park it in its slot
        logic drain;      // emit the stored item at the head slot
    } iorob_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_order;   // input sequence number equals the expected one
        logic in_window;  // input lies less than WINDOW places ahead
        logic dup;        // the slot for the input is already occupied
        logic more;       // the slot after the head holds an item
        logic out_free;   // the output register can take an item this cycle
    } iorob_sts_t;

endpackage

// ===== design/in_order_reorder_buffer.sv =====
// Top level of the in-order reorder buffer: controller, datapath and checks.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata: seq_number, result_word, context_tag
//  m_       | out       | m_tvalid/m_tready  | m_tdata: seq_out, result_out, context_out;
//           |           |                    | m_tuser: rejected; m_tlast: last
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data: first_sequence
//
//  An item that is stored or rejected is handled on its own; an in-order item is emitted
//  and is followed by each stored item that drains behind it, in order, as one
//  burst. The rate is set by the single output register, which takes one result
//  per cycle while m_tready is high.
//  Reset (aresetn low, synchronous) empties every slot and expects sequence 0;
//  a write on cfg_wr_en does the same with the written number.
//  s_tready is low during a drain burst and whenever the output register holds
//  an item that is not taken in this cycle.

module in_order_reorder_buffer import iorob_pkg::*; #(
    parameter int WINDOW        = DEF_WINDOW,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration: first_sequence.
    input  logic               cfg_wr_en,
    input  logic [SEQ_W-1:0]   cfg_wr_data,
    // Input items.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // seq_number[31:0], result_word[63:32], context_tag[95:64]
    // Result items.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // seq_out[31:0], result_out[63:32], context_out[95:64]
    output logic               m_tuser,   // rejected
    output logic               m_tlast
);

    iorob_cmd_t cmd;
    iorob_sts_t sts;

    // The controller decides what to do with each item; it never touches payload.
    iorob_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .s_tvalid  (s_tvalid),
        .sts       (sts),
        .s_tready  (s_tready),
        .cmd       (cmd)
    );

    // The datapath holds the expected number, the slot window and the output register.
    iorob_datapath #(
        .WINDOW        (WINDOW),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef ASSERT_OFF
    // The controller issues at most one datapath command per cycle.
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_in, cmd.reject_in, cmd.store_in, cmd.drain}))
        else $error("more than one datapath command in a cycle");

    // A drain step only loads the output register when it is free.
    a_drain_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.drain |-> sts.out_free)
        else $error("drain issued while the output register is occupied");

    // An in-order item with a stored successor starts a burst that blocks input.
    a_burst_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_in && sts.more && !cfg_wr_en) |=> !s_tready)
        else $error("input accepted during a drain burst");

    // A rejected item is always a burst of its own.
    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.reject_in |=> (m_tvalid && m_tuser && m_tlast))
        else $error("rejected item not returned alone");
`endif

endmodule

// ===== design/iorob_ctrl.sv =====
// Controller state machine: classifies each accepted item and sequences drain bursts.
`timescale 1ns / 1ps

module iorob_ctrl import iorob_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       s_tvalid,
    input  iorob_sts_t sts,
    output logic       s_tready,
    output iorob_cmd_t cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    if (sts.in_order) begin
                        cmd.emit_in = 1'b1;
                        if (sts.more) begin
                            state_next = ST_DRAIN;
                        end
                    end else if (sts.in_window && !sts.dup) begin
                        cmd.store_in = 1'b1;
                    end else begin
                        cmd.reject_in = 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (sts.out_free) begin
                    cmd.drain = 1'b1;
                    if (!sts.more) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/iorob_datapath.sv =====
// Datapath: expected-sequence counter, slot window with occupancy bits, and output register.
`timescale 1ns / 1ps

module iorob_datapath import iorob_pkg::*; #(
    parameter int WINDOW        = DEF_WINDOW,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [SEQ_W-1:0]   cfg_wr_data,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               m_tready,
    input  iorob_cmd_t         cmd,
    output iorob_sts_t         sts,
    output logic               m_tvalid,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    localparam int SW = (PAYLOAD_WIDTH < WORD_W) ? PAYLOAD_WIDTH : WORD_W;
    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [IW:0]      WIN_EXT   = (IW + 1)'(WINDOW);
    localparam logic [SEQ_W-1:0] WIN_SEQ   = SEQ_W'(WINDOW);
    localparam logic [IW-1:0]    LAST_SLOT = IW'(WINDOW - 1);

    logic [SEQ_W-1:0]   next_exp_reg, next_exp_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [WINDOW-1:0]  valid_reg, valid_next;
    logic [2*SW-1:0]    slot_mem [WINDOW];
    logic [2*SW-1:0]    rd_data_reg;

    logic               out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    logic               out_user_reg, out_user_next;
    logic               out_last_reg, out_last_next;

    logic [SEQ_W-1:0]   in_seq;
    logic [SW-1:0]      in_res;
    logic [SW-1:0]      in_ctx;
    logic [SEQ_W-1:0]   seq_ahead;
    logic [IW:0]        slot_sum;
    logic [IW-1:0]      slot_idx;
    logic [IW-1:0]      head_inc;
    logic               advance;
    logic               load;

    assign in_seq = s_tdata[SEQ_W-1:0];
    assign in_res = s_tdata[SEQ_W +: SW];
    assign in_ctx = s_tdata[SEQ_W + WORD_W +: SW];

    // Distance ahead of the expected number, modulo 2^32.
    assign seq_ahead = in_seq - next_exp_reg;
    assign slot_sum  = {1'b0, head_reg} + {1'b0, seq_ahead[IW-1:0]};
    assign slot_idx = (slot_sum >= WIN_EXT) ? IW'(slot_sum - WIN_EXT) : slot_sum[IW-1:0];
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;

    assign advance = cmd.emit_in || cmd.drain;
    assign load    = cmd.emit_in || cmd.reject_in || cmd.drain;

    assign sts.in_order  = (seq_ahead == '0);
    assign sts.in_window = (seq_ahead < WIN_SEQ);
    assign sts.dup       = valid_reg[slot_idx];
    assign sts.more      = valid_reg[head_inc];
    assign sts.out_free  = !out_valid_reg || m_tready;

    always_comb begin
        next_exp_next = next_exp_reg;
        head_next     = head_reg;
        valid_next    = valid_reg;
        if (cfg_wr_en) begin
            next_exp_next = cfg_wr_data;
            head_next     = '0;
            valid_next    = '0;
        end else begin
            if (advance) begin
                next_exp_next = next_exp_reg + 1'b1;
                head_next     = head_inc;
            end
            if (cmd.store_in) begin
                valid_next[slot_idx] = 1'b1;
            end
            if (cmd.drain) begin
                valid_next[head_reg] = 1'b0;
            end
        end
    end

    // Slot memory. The read port follows the head, so the registered read
    // data always holds the entry at the current head slot.
    always_ff @(posedge aclk) begin
        if (cmd.store_in) begin
            slot_mem[slot_idx] <= {in_ctx, in_res};
        end
        rd_data_reg <= slot_mem[head_next];
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_user_next  = cmd.reject_in;
            out_last_next  = cmd.reject_in || !sts.more;
            if (cmd.drain) begin
                out_data_next = {WORD_W'(rd_data_reg[2*SW-1:SW]),
                                 WORD_W'(rd_data_reg[SW-1:0]),
                                 next_exp_reg};
            end else begin
                out_data_next = {WORD_W'(in_ctx), WORD_W'(in_res), in_seq};
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_exp_reg  <= '0;
            head_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            next_exp_reg  <= next_exp_next;
            head_reg      <= head_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
